// File: hdl/thds_pkg.sv
// shared types, constants and helpers for the temperature / humidity display smoother
package thds_pkg;

  localparam int unsigned TEMP_W   = 8;
  localparam int unsigned HUMI_W   = 7;
  localparam int unsigned TRAW_W   = 12;
  localparam int unsigned HRAW_W   = 10;
  localparam int unsigned UPTIME_W = 16;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned TIMER_W  = 10;
  localparam int unsigned HOLD_W   = 2;

  localparam logic [TIMER_W-1:0]  FAULT_STEP_TICKS  = 10'd600;
  localparam logic [HUMI_W-1:0]   FAULT_WALK_TOP    = 7'd60;
  localparam logic [HUMI_W-1:0]   FAULT_WALK_BOTTOM = 7'd55;
  localparam logic [HUMI_W-1:0]   FAULT_START_HUMI  = 7'd50;
  localparam logic [UPTIME_W-1:0] OFFSET_SWITCH_SEC = 16'd3600;
  localparam logic [UPTIME_W-1:0] STARTUP_SEC       = 16'd5;
  localparam logic [8:0]          EARLY_OFFSET      = 9'd8;
  localparam logic [8:0]          LATE_OFFSET       = 9'd10;
  localparam logic [HOLD_W-1:0]   HOLD_TICKS        = 2'd3;
  localparam logic [TRAW_W-1:0]   ROUND_HALF        = 12'd5;

  localparam logic [TEMP_W-1:0] TEMP_HIGH_RESET = 8'd50;
  localparam logic [TEMP_W-1:0] TEMP_LOW_RESET  = 8'd0;
  localparam logic [HUMI_W-1:0] HUMI_HIGH_RESET = 7'd95;
  localparam logic [HUMI_W-1:0] HUMI_LOW_RESET  = 7'd20;

  // reciprocal of ten scaled by 2^16, exact for dividends below 16384
  localparam logic [12:0] RECIP_TEN = 13'd6554;

  typedef enum logic [1:0] {
    CFG_TEMP_HIGH = 2'd0,
    CFG_TEMP_LOW  = 2'd1,
    CFG_HUMI_HIGH = 2'd2,
    CFG_HUMI_LOW  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                       sensor_fault;
    logic                       reading_valid;
    logic signed [TRAW_W-1:0]   temp_tenths;
    logic        [HRAW_W-1:0]   humi_tenths;
    logic        [UPTIME_W-1:0] uptime_seconds;
  } sample_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] shown_temp;
    logic        [HUMI_W-1:0] shown_humi;
  } display_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_high;
    logic signed [TEMP_W-1:0] temp_low;
    logic        [HUMI_W-1:0] humi_high;
    logic        [HUMI_W-1:0] humi_low;
  } limits_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic        [HUMI_W-1:0] humi;
    logic                     startup;
  } target_t;

  // floor(a / 10) for a below 2560
  function automatic logic [7:0] div_ten(input logic [TRAW_W-1:0] a);
    logic [24:0] prod;
    prod = {13'd0, a} * {12'd0, RECIP_TEN};
    return prod[23:16];
  endfunction

endpackage

// File: hdl/thds_convert.sv
// rounding, offset and clamping of one raw reading into display targets
module thds_convert (
  input  thds_pkg::sample_t smp,
  input  thds_pkg::limits_t lim,
  output thds_pkg::target_t tgt
);

  logic                              neg;
  logic [thds_pkg::TRAW_W-1:0]       t_bits;
  logic [thds_pkg::TRAW_W-1:0]       t_mag;
  logic [7:0]                        t_quot;
  logic signed [9:0]                 t_round;
  logic signed [9:0]                 t_hi;
  logic signed [9:0]                 t_lo;
  logic signed [9:0]                 t_clamp;
  logic [thds_pkg::TRAW_W-1:0]       h_sum;
  logic [7:0]                        h_quot;
  logic signed [8:0]                 h_off;
  logic signed [8:0]                 h_hi;
  logic signed [8:0]                 h_lo;
  logic signed [8:0]                 h_clamp;

  always_comb begin
    t_bits  = smp.temp_tenths;
    neg     = t_bits[thds_pkg::TRAW_W-1];
    t_mag   = neg ? (~t_bits + 12'd1) : t_bits;
    t_quot  = thds_pkg::div_ten(t_mag + thds_pkg::ROUND_HALF);
    t_round = neg ? -$signed({2'b00, t_quot}) : $signed({2'b00, t_quot});
    t_hi    = {{2{lim.temp_high[thds_pkg::TEMP_W-1]}}, lim.temp_high};
    t_lo    = {{2{lim.temp_low[thds_pkg::TEMP_W-1]}}, lim.temp_low};
    if (t_round > t_hi) begin
      t_clamp = t_hi;
    end else if (t_round < t_lo) begin
      t_clamp = t_lo;
    end else begin
      t_clamp = t_round;
    end

    h_sum  = {2'b00, smp.humi_tenths} + thds_pkg::ROUND_HALF;
    h_quot = thds_pkg::div_ten(h_sum);
    if (smp.uptime_seconds < thds_pkg::OFFSET_SWITCH_SEC) begin
      h_off = $signed({1'b0, h_quot}) - $signed(thds_pkg::EARLY_OFFSET);
    end else begin
      h_off = $signed({1'b0, h_quot}) - $signed(thds_pkg::LATE_OFFSET);
    end
    h_hi = $signed({2'b00, lim.humi_high});
    h_lo = $signed({2'b00, lim.humi_low});
    if (h_off > h_hi) begin
      h_clamp = h_hi;
    end else if (h_off < h_lo) begin
      h_clamp = h_lo;
    end else begin
      h_clamp = h_off;
    end

    tgt.temp    = t_clamp[thds_pkg::TEMP_W-1:0];
    tgt.humi    = h_clamp[thds_pkg::HUMI_W-1:0];
    tgt.startup = smp.uptime_seconds <= thds_pkg::STARTUP_SEC;
  end

endmodule

// File: hdl/thds_state.sv
// display registers with change debounce and the sensor fault walk
module thds_state (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              sensor_fault,
  input  logic              reading_valid,
  input  thds_pkg::target_t tgt,
  output thds_pkg::display_t shown
);

  logic signed [thds_pkg::TEMP_W-1:0]  disp_temp;
  logic signed [thds_pkg::TEMP_W-1:0]  disp_temp_next;
  logic [thds_pkg::HUMI_W-1:0]         disp_humi;
  logic [thds_pkg::HUMI_W-1:0]         disp_humi_next;
  logic [thds_pkg::HOLD_W-1:0]         temp_hold;
  logic [thds_pkg::HOLD_W-1:0]         temp_hold_next;
  logic [thds_pkg::HOLD_W-1:0]         humi_hold;
  logic [thds_pkg::HOLD_W-1:0]         humi_hold_next;
  logic [thds_pkg::TIMER_W-1:0]        fault_timer;
  logic [thds_pkg::TIMER_W-1:0]        fault_timer_next;
  logic                                walk_up;
  logic                                walk_up_next;
  logic [thds_pkg::HOLD_W-1:0]         temp_hold_inc;
  logic [thds_pkg::HOLD_W-1:0]         humi_hold_inc;
  logic [thds_pkg::TIMER_W-1:0]        timer_inc;
  logic [thds_pkg::HUMI_W-1:0]         walk_base;
  logic [thds_pkg::HUMI_W-1:0]         walk_step;

  always_comb begin
    disp_temp_next   = disp_temp;
    disp_humi_next   = disp_humi;
    temp_hold_next   = temp_hold;
    humi_hold_next   = humi_hold;
    fault_timer_next = fault_timer;
    walk_up_next     = walk_up;
    temp_hold_inc    = temp_hold + 2'd1;
    humi_hold_inc    = humi_hold + 2'd1;
    timer_inc        = fault_timer + 10'd1;
    walk_base        = (fault_timer == '0) ? thds_pkg::FAULT_START_HUMI : disp_humi;
    walk_step        = walk_up ? (walk_base + 7'd1) : (walk_base - 7'd1);

    if (!sensor_fault) begin
      fault_timer_next = '0;
      if (reading_valid) begin
        if (tgt.startup) begin
          disp_temp_next = tgt.temp;
          disp_humi_next = tgt.humi;
          temp_hold_next = '0;
          humi_hold_next = '0;
        end else begin
          if (disp_temp != tgt.temp) begin
            if (temp_hold_inc >= thds_pkg::HOLD_TICKS) begin
              temp_hold_next = '0;
              disp_temp_next = tgt.temp;
            end else begin
              temp_hold_next = temp_hold_inc;
            end
          end else begin
            temp_hold_next = '0;
          end
          if (disp_humi != tgt.humi) begin
            if (humi_hold_inc >= thds_pkg::HOLD_TICKS) begin
              humi_hold_next = '0;
              disp_humi_next = tgt.humi;
            end else begin
              humi_hold_next = humi_hold_inc;
            end
          end else begin
            humi_hold_next = '0;
          end
        end
      end
    end else begin
      disp_humi_next = walk_base;
      if (timer_inc >= thds_pkg::FAULT_STEP_TICKS) begin
        fault_timer_next = 10'd1;
        disp_humi_next   = walk_step;
        if (walk_up) begin
          if (walk_step >= thds_pkg::FAULT_WALK_TOP) begin
            walk_up_next = 1'b0;
          end
        end else begin
          if (walk_step <= thds_pkg::FAULT_WALK_BOTTOM) begin
            walk_up_next = 1'b1;
          end
        end
      end else begin
        fault_timer_next = timer_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_temp   <= '0;
      disp_humi   <= '0;
      temp_hold   <= '0;
      humi_hold   <= '0;
      fault_timer <= '0;
      walk_up     <= 1'b1;
    end else if (advance) begin
      disp_temp   <= disp_temp_next;
      disp_humi   <= disp_humi_next;
      temp_hold   <= temp_hold_next;
      humi_hold   <= humi_hold_next;
      fault_timer <= fault_timer_next;
      walk_up     <= walk_up_next;
    end
  end

  assign shown.shown_temp = disp_temp;
  assign shown.shown_humi = disp_humi;

endmodule

// File: hdl/temp_humidity_display_smoother.sv
// top level of the temperature / humidity display smoother
//
// sample channel: one request per sensor tick (sample_valid / sample_stall,
// payload sample). disp channel: one request back per sample (disp_valid /
// disp_stall, payload disp) carrying the displayed temperature and humidity.
// an accepted sample is held in the input register until the display
// registers are free to take it; its result is then written into the display
// registers and is offered on disp from then on.
// throughput is one sample per cycle while disp is not stalled; the display
// registers double as the result register, so the next sample is taken
// while a result is pending. when disp_stall is high the result holds and,
// once the input register is full, sample_stall rises in the same cycle.
// display limits are written through cfg_wen / cfg_index / cfg_data. the user
// must write them only while no request is in flight; the block does not enforce it.
// synchronous reset empties both registers, clears the display and
// debounce state, sets the fault walk upward and reloads the default
// limits (temperature 0..50, humidity 20..95).
module temp_humidity_display_smoother (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  thds_pkg::sample_t            sample,
  output logic                         disp_valid,
  input  logic                         disp_stall,
  output thds_pkg::display_t           disp,
  input  logic                         cfg_wen,
  input  logic [1:0]                   cfg_index,
  input  logic [thds_pkg::CFG_W-1:0]   cfg_data
);

  logic               sample_full;
  thds_pkg::sample_t  sample_q;
  logic               out_free;
  logic               advance;
  logic               accept;
  thds_pkg::limits_t  lim;
  thds_pkg::target_t  tgt;

  assign out_free     = !disp_valid || !disp_stall;
  assign advance      = sample_full && out_free;
  assign sample_stall = sample_full && !out_free;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_full <= 1'b0;
      disp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        sample_full <= 1'b1;
      end else if (advance) begin
        sample_full <= 1'b0;
      end
      if (advance) begin
        disp_valid <= 1'b1;
      end else if (!disp_stall) begin
        disp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.temp_high <= thds_pkg::TEMP_HIGH_RESET;
      lim.temp_low  <= thds_pkg::TEMP_LOW_RESET;
      lim.humi_high <= thds_pkg::HUMI_HIGH_RESET;
      lim.humi_low  <= thds_pkg::HUMI_LOW_RESET;
    end else if (cfg_wen) begin
      case (thds_pkg::cfg_index_t'(cfg_index))
        thds_pkg::CFG_TEMP_HIGH: lim.temp_high <= cfg_data;
        thds_pkg::CFG_TEMP_LOW:  lim.temp_low  <= cfg_data;
        thds_pkg::CFG_HUMI_HIGH: lim.humi_high <= cfg_data[thds_pkg::HUMI_W-1:0];
        thds_pkg::CFG_HUMI_LOW:  lim.humi_low  <= cfg_data[thds_pkg::HUMI_W-1:0];
        default: ;
      endcase
    end
  end

  thds_convert u_convert (
    .smp (sample_q),
    .lim (lim),
    .tgt (tgt)
  );

  thds_state u_state (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .sensor_fault  (sample_q.sensor_fault),
    .reading_valid (sample_q.reading_valid),
    .tgt           (tgt),
    .shown         (disp)
  );

endmodule
